FILE: design/swk_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the swerve wheel kinematics block.
// No dependencies.
package swk_pkg;

  localparam int WheelCount = 4;
  localparam int PosW       = 16;
  localparam int VelW       = 16;
  localparam int AngW       = 15;
  localparam int SpdW       = 24;
  localparam int ModeW      = 2;
  localparam int CfgIdxW    = 3;
  localparam int DivSteps   = 24;
  localparam int SqrtSteps  = 26;
  localparam int StepW      = 5;
  localparam int WheelW     = 2;

  localparam logic signed [AngW-1:0] HalfPiQ13 = 15'sd12868;

  typedef enum logic [ModeW-1:0] {
    MODE_TURN      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_SPIN      = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_W0_X = 3'd0,
    CFG_W0_Y = 3'd1,
    CFG_W1_X = 3'd2,
    CFG_W1_Y = 3'd3,
    CFG_W2_X = 3'd4,
    CFG_W2_Y = 3'd5,
    CFG_W3_X = 3'd6,
    CFG_W3_Y = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_FIX,
    OP_PREP,
    OP_SQ,
    OP_SUM,
    OP_RUN,
    OP_SPEED,
    OP_STORE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [StepW-1:0]  step;
    logic [WheelW-1:0] wheel;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic v_zero;
  } status_t;

  // atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input logic [StepW-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      5'd10:   r = 30'd1048576;
      5'd11:   r = 30'd524288;
      5'd12:   r = 30'd262144;
      5'd13:   r = 30'd131072;
      5'd14:   r = 30'd65536;
      5'd15:   r = 30'd32768;
      5'd16:   r = 30'd16384;
      5'd17:   r = 30'd8192;
      5'd18:   r = 30'd4096;
      5'd19:   r = 30'd2048;
      5'd20:   r = 30'd1024;
      5'd21:   r = 30'd512;
      5'd22:   r = 30'd256;
      5'd23:   r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/swk_in_if.sv
`timescale 1ns / 1ps
// Request channel: body velocity command.
// Depends on swk_pkg.
interface swk_in_if;
  import swk_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] vel_x;
  logic signed [VelW-1:0] vel_y;
  logic signed [VelW-1:0] yaw_rate;

  modport source(output valid, vel_x, vel_y, yaw_rate, input ready);
  modport sink(input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

FILE: design/swk_out_if.sv
`timescale 1ns / 1ps
// Result channel: mode, per-wheel steering angles and speeds.
// Depends on swk_pkg.
interface swk_out_if;
  import swk_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       mode;
  logic signed [AngW-1:0] angle0;
  logic signed [AngW-1:0] angle1;
  logic signed [AngW-1:0] angle2;
  logic signed [AngW-1:0] angle3;
  logic signed [SpdW-1:0] speed0;
  logic signed [SpdW-1:0] speed1;
  logic signed [SpdW-1:0] speed2;
  logic signed [SpdW-1:0] speed3;

  modport source(output valid, mode, angle0, angle1, angle2, angle3,
                 speed0, speed1, speed2, speed3, input ready);
  modport sink(input valid, mode, angle0, angle1, angle2, angle3,
               speed0, speed1, speed2, speed3, output ready);
endinterface

FILE: design/swerve_wheel_kinematics_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake     | payload
// req_i   | in  | valid/ready   | vel_x, vel_y, yaw_rate
// res_o   | out | valid/ready   | mode, angle0..3, speed0..3
// cfg     | in  | cfg_we_i only | cfg_idx_i, cfg_data_i (wheel positions)
// One request at a time. Turning: start, the divide and its fix, then per wheel prep,
// square, sum, the 26-step square root run with the CORDIC alongside, speed and store;
// then output. Spin skips the divide; translate skips it too and does one wheel pass.
// The result holds until taken; no request is taken meanwhile.
// Reset restores default wheel positions and zero held angles.
module swerve_wheel_kinematics_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swk_in_if.sink                        req_i,
  swk_out_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [swk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [swk_pkg::PosW-1:0]      cfg_data_i
);
  import swk_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  logic signed [AngW-1:0] angle [WheelCount];
  logic signed [SpdW-1:0] speed [WheelCount];

  swk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swk_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .vel_x_i    (req_i.vel_x),
    .vel_y_i    (req_i.vel_y),
    .yaw_rate_i (req_i.yaw_rate),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mode_o     (res_o.mode),
    .angle_o    (angle),
    .speed_o    (speed)
  );

  assign res_o.angle0 = angle[0];
  assign res_o.angle1 = angle[1];
  assign res_o.angle2 = angle[2];
  assign res_o.angle3 = angle[3];
  assign res_o.speed0 = speed[0];
  assign res_o.speed1 = speed[1];
  assign res_o.speed2 = speed[2];
  assign res_o.speed3 = speed[3];

endmodule

FILE: design/swk_datapath.sv
`timescale 1ns / 1ps
// Datapath: wheel position registers, centre dividers, CORDIC, square root,
// speed multiply and result registers. Depends on swk_pkg.
module swk_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swk_pkg::cmd_t                  cmd_i,
  output swk_pkg::status_t               status_o,
  input  logic signed [swk_pkg::VelW-1:0] vel_x_i,
  input  logic signed [swk_pkg::VelW-1:0] vel_y_i,
  input  logic signed [swk_pkg::VelW-1:0] yaw_rate_i,
  input  logic                           cfg_we_i,
  input  logic [swk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [swk_pkg::PosW-1:0]       cfg_data_i,
  output logic [swk_pkg::ModeW-1:0]      mode_o,
  output logic signed [swk_pkg::AngW-1:0] angle_o [swk_pkg::WheelCount],
  output logic signed [swk_pkg::SpdW-1:0] speed_o [swk_pkg::WheelCount]
);
  import swk_pkg::*;

  localparam int DW = 26;
  localparam int CW = 30;
  localparam int ZW = 33;
  localparam int NW = 51;
  localparam int MW = 25;
  localparam int QW = 24;
  localparam int RW = 17;
  localparam int PW = 42;

  function automatic logic [VelW-1:0] abs16(input logic signed [VelW-1:0] v);
    return v[VelW-1] ? VelW'(-v) : VelW'(v);
  endfunction

  logic signed [PosW-1:0] pos_x_q [WheelCount];
  logic signed [PosW-1:0] pos_y_q [WheelCount];

  logic signed [VelW-1:0] vx_q, vy_q, w_q;
  mode_e                  mode_q;
  logic [QW-1:0]          nx_q, ny_q;
  logic [RW-1:0]          rx_q, ry_q;
  logic [VelW-1:0]        dv_q;
  logic                   negx_q, negy_q;
  logic signed [24:0]     cx_q, cy_q;
  logic signed [DW-1:0]   a_q, b_q;
  logic                   zero_q, vert_q;
  logic [2*MW-1:0]        sqa_q, sqb_q;
  logic [NW-1:0]          sn_q, sres_q, sbit_q;
  logic signed [CW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [AngW-1:0] ang_q [WheelCount];
  logic signed [SpdW-1:0] spd_q [WheelCount];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q[0] <= 16'sd256;
      pos_y_q[0] <= -16'sd256;
      pos_x_q[1] <= 16'sd256;
      pos_y_q[1] <= 16'sd256;
      pos_x_q[2] <= -16'sd256;
      pos_y_q[2] <= 16'sd256;
      pos_x_q[3] <= -16'sd256;
      pos_y_q[3] <= -16'sd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_W0_X: pos_x_q[0] <= cfg_data_i;
        CFG_W0_Y: pos_y_q[0] <= cfg_data_i;
        CFG_W1_X: pos_x_q[1] <= cfg_data_i;
        CFG_W1_Y: pos_y_q[1] <= cfg_data_i;
        CFG_W2_X: pos_x_q[2] <= cfg_data_i;
        CFG_W2_Y: pos_y_q[2] <= cfg_data_i;
        CFG_W3_X: pos_x_q[3] <= cfg_data_i;
        CFG_W3_Y: pos_y_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider step
  logic [RW-1:0] rx_sh, ry_sh, rx_d, ry_d;
  logic          gex, gey;
  always_comb begin
    rx_sh = {rx_q[RW-2:0], nx_q[QW-1]};
    ry_sh = {ry_q[RW-2:0], ny_q[QW-1]};
    gex   = rx_sh >= {1'b0, dv_q};
    gey   = ry_sh >= {1'b0, dv_q};
    rx_d  = gex ? rx_sh - {1'b0, dv_q} : rx_sh;
    ry_d  = gey ? ry_sh - {1'b0, dv_q} : ry_sh;
  end

  // wheel direction
  logic signed [DW-1:0] dx, dy, a_raw, b_raw, a_f, b_f;
  always_comb begin
    dx = DW'(pos_x_q[cmd_i.wheel]) - DW'(cx_q);
    dy = DW'(pos_y_q[cmd_i.wheel]) - DW'(cy_q);
    if (status_o.w_zero) begin
      a_raw = DW'(vx_q);
      b_raw = DW'(vy_q);
    end else begin
      a_raw = dy;
      b_raw = -dx;
    end
    a_f = a_raw[DW-1] ? -a_raw : a_raw;
    b_f = a_raw[DW-1] ? -b_raw : b_raw;
  end

  logic [MW-1:0] abs_a, abs_b;
  assign abs_a = a_q[DW-1] ? MW'(-a_q) : MW'(a_q);
  assign abs_b = b_q[DW-1] ? MW'(-b_q) : MW'(b_q);

  // square root and CORDIC steps
  logic [NW-1:0]        s_try;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  assign s_try = sres_q + sbit_q;
  assign xs    = x_q >>> cmd_i.step;
  assign ys    = y_q >>> cmd_i.step;
  assign at    = ZW'(atan_q30(cmd_i.step));

  // result shaping
  logic signed [ZW-1:0]   zs;
  logic signed [15:0]     zr;
  logic signed [AngW-1:0] ang_new;
  logic signed [PW-9:0]   pr_sh;
  logic signed [SpdW-1:0] spd_rot, spd_tr;
  always_comb begin
    zs = z_q + ZW'(65536);
    zr = zs[ZW-1:17];
    if (vert_q || zr > 16'sd12868 || zr <= -16'sd12868) begin
      ang_new = HalfPiQ13;
    end else begin
      ang_new = zr[AngW-1:0];
    end
    pr_sh = prod_q[PW-1:8];
    if (pr_sh > (PW-8)'(8388607)) begin
      spd_rot = 24'sh7FFFFF;
    end else if (pr_sh < -(PW-8)'(8388608)) begin
      spd_rot = 24'sh800000;
    end else begin
      spd_rot = pr_sh[SpdW-1:0];
    end
    spd_tr = SpdW'(sres_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        vx_q   <= vel_x_i;
        vy_q   <= vel_y_i;
        w_q    <= yaw_rate_i;
        if (yaw_rate_i == '0) begin
          mode_q <= MODE_TRANSLATE;
        end else if (vel_x_i == '0 && vel_y_i == '0) begin
          mode_q <= MODE_SPIN;
        end else begin
          mode_q <= MODE_TURN;
        end
        nx_q   <= {abs16(vel_y_i), 8'b0};
        ny_q   <= {abs16(vel_x_i), 8'b0};
        rx_q   <= '0;
        ry_q   <= '0;
        dv_q   <= abs16(yaw_rate_i);
        negx_q <= (vel_y_i > 16'sd0) ^ yaw_rate_i[VelW-1];
        negy_q <= vel_x_i[VelW-1] ^ yaw_rate_i[VelW-1];
        cx_q   <= '0;
        cy_q   <= '0;
      end
      OP_DIV: begin
        rx_q <= rx_d;
        ry_q <= ry_d;
        nx_q <= {nx_q[QW-2:0], gex};
        ny_q <= {ny_q[QW-2:0], gey};
      end
      OP_FIX: begin
        cx_q <= negx_q ? -$signed({1'b0, nx_q}) : $signed({1'b0, nx_q});
        cy_q <= negy_q ? -$signed({1'b0, ny_q}) : $signed({1'b0, ny_q});
      end
      OP_PREP: begin
        a_q    <= a_f;
        b_q    <= b_f;
        zero_q <= (a_raw == '0) && (b_raw == '0);
        vert_q <= (a_f == '0);
        x_q    <= CW'(a_f);
        y_q    <= CW'(b_f);
        z_q    <= '0;
      end
      OP_SQ: begin
        sqa_q <= abs_a * abs_a;
        sqb_q <= abs_b * abs_b;
      end
      OP_SUM: begin
        sn_q   <= NW'(sqa_q) + NW'(sqb_q);
        sres_q <= '0;
        sbit_q <= NW'(1) << (NW - 1);
      end
      OP_RUN: begin
        if (sn_q >= s_try) begin
          sn_q   <= sn_q - s_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
        if (int'(cmd_i.step) < CORDIC_STEPS) begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end
        end
      end
      OP_SPEED: begin
        prod_q <= $signed({1'b0, sres_q[MW-1:0]}) * w_q;
      end
      default: ;
    endcase
  end

  // result registers; the angles double as the held angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WheelCount; i++) begin
        ang_q[i] <= '0;
        spd_q[i] <= '0;
      end
    end else if (cmd_i.op == OP_LOAD) begin
      for (int i = 0; i < WheelCount; i++) begin
        spd_q[i] <= '0;
      end
    end else if (cmd_i.op == OP_STORE && !zero_q) begin
      if (status_o.w_zero) begin
        for (int i = 0; i < WheelCount; i++) begin
          ang_q[i] <= ang_new;
          spd_q[i] <= spd_tr;
        end
      end else begin
        ang_q[cmd_i.wheel] <= ang_new;
        spd_q[cmd_i.wheel] <= spd_rot;
      end
    end
  end

  assign status_o.w_zero = (w_q == '0);
  assign status_o.v_zero = (vx_q == '0) && (vy_q == '0);
  assign mode_o          = mode_q;
  assign angle_o         = ang_q;
  assign speed_o         = spd_q;

endmodule

FILE: design/swk_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences divide, per-wheel CORDIC/square root and output.
// Depends on swk_pkg.
module swk_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  swk_pkg::status_t status_i,
  output swk_pkg::cmd_t    cmd_o
);
  import swk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_FIX, S_PREP, S_SQ, S_SUM, S_RUN, S_SPEED, S_STORE, S_OUT
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic [WheelW-1:0] wheel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      wheel_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_START;
        end
        S_START: begin
          step_q  <= '0;
          wheel_q <= '0;
          state_q <= (status_i.w_zero || status_i.v_zero) ? S_PREP : S_DIV;
        end
        S_DIV: begin
          if (step_q == StepW'(DivSteps - 1)) begin
            step_q  <= '0;
            state_q <= S_FIX;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_FIX:   state_q <= S_PREP;
        S_PREP:  state_q <= S_SQ;
        S_SQ:    state_q <= S_SUM;
        S_SUM: begin
          step_q  <= '0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          if (step_q == StepW'(SqrtSteps - 1)) begin
            step_q  <= '0;
            state_q <= S_SPEED;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_SPEED: state_q <= S_STORE;
        S_STORE: begin
          if (status_i.w_zero || wheel_q == WheelW'(WheelCount - 1)) begin
            state_q <= S_OUT;
          end else begin
            wheel_q <= wheel_q + 1'b1;
            state_q <= S_PREP;
          end
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.step  = step_q;
    cmd_o.wheel = wheel_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DIV:   cmd_o.op = OP_DIV;
      S_FIX:   cmd_o.op = OP_FIX;
      S_PREP:  cmd_o.op = OP_PREP;
      S_SQ:    cmd_o.op = OP_SQ;
      S_SUM:   cmd_o.op = OP_SUM;
      S_RUN:   cmd_o.op = OP_RUN;
      S_SPEED: cmd_o.op = OP_SPEED;
      S_STORE: cmd_o.op = OP_STORE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

FILE: design/swk_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the swerve wheel kinematics top, with its bind.
// Depends on swk_pkg and swerve_wheel_kinematics_top.
module swk_port_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [swk_pkg::ModeW-1:0]     mode_i,
  input logic signed [swk_pkg::AngW-1:0] angle0_i,
  input logic signed [swk_pkg::AngW-1:0] angle1_i,
  input logic signed [swk_pkg::AngW-1:0] angle2_i,
  input logic signed [swk_pkg::AngW-1:0] angle3_i
);
  import swk_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(mode_i) && $stable(angle0_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_i && res_valid_i))
    else $error("request taken while result pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i && !res_valid_i)
    else $error("not busy after request");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (mode_i == MODE_TURN || mode_i == MODE_TRANSLATE ||
                     mode_i == MODE_SPIN))
    else $error("bad mode code");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (angle0_i <= HalfPiQ13 && angle0_i > -HalfPiQ13 &&
                     angle1_i <= HalfPiQ13 && angle1_i > -HalfPiQ13 &&
                     angle2_i <= HalfPiQ13 && angle2_i > -HalfPiQ13 &&
                     angle3_i <= HalfPiQ13 && angle3_i > -HalfPiQ13))
    else $error("angle out of range");

endmodule

bind swerve_wheel_kinematics_top swk_port_props u_swk_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .mode_i      (res_o.mode),
  .angle0_i    (res_o.angle0),
  .angle1_i    (res_o.angle1),
  .angle2_i    (res_o.angle2),
  .angle3_i    (res_o.angle3)
);
